// File: rtl/core/rocac_pkg.sv
// ----------------------------------------------------------------------------
// Rectangle overlay area counter package
// Command and status codes, field widths and the structs that pass between
// the cell store, the area store and the controller.
// ----------------------------------------------------------------------------
package rocac_pkg;

  localparam int CMD_W      = 2;
  localparam int COORD_W    = 8;
  localparam int SPAN_W     = 9;
  localparam int STAT_W     = 2;
  localparam int ID_W       = 7;
  localparam int AREA_OUT_W = 17;

  localparam logic [CMD_W-1:0] CMD_PAINT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REPORT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_LIMIT   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd2;
  localparam logic [STAT_W-1:0] STAT_CLEARED = 2'd3;

  typedef struct packed {
    logic               paint;
    logic               clear;
    logic [COORD_W-1:0] top_row;
    logic [COORD_W-1:0] left_col;
    logic [SPAN_W-1:0]  span_rows;
    logic [SPAN_W-1:0]  span_cols;
    logic [ID_W-1:0]    id;
  } grid_cmd_t;

  typedef struct packed {
    logic            active;
    logic            beat_valid;
    logic [ID_W-1:0] old_owner;
  } grid_stat_t;

  typedef struct packed {
    logic            clear;
    logic            paint_start;
    logic            commit;
    logic            report_rd;
    logic [ID_W-1:0] id;
  } area_cmd_t;

  typedef struct packed {
    logic                  busy;
    logic [AREA_OUT_W-1:0] rd_area;
    logic [AREA_OUT_W-1:0] new_area;
  } area_stat_t;

endpackage

// File: rtl/core/rocac_grid.sv
// ----------------------------------------------------------------------------
// Cell owner store
// Holds the owner id of every grid cell, walks a clipped rectangle one cell
// per cycle, streams the previous owners out and writes the new id back.
// ----------------------------------------------------------------------------
module rocac_grid #(
  parameter int GRID_SIDE = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  rocac_pkg::grid_cmd_t  cmd,
  output rocac_pkg::grid_stat_t stat
);

  localparam int CELLS   = GRID_SIDE * GRID_SIDE;
  localparam int CELL_AW = $clog2(CELLS);
  localparam int LEN_W   = $clog2(GRID_SIDE + 1);
  localparam int EXT_W   = (LEN_W > 10) ? LEN_W : 10;
  localparam logic [CELL_AW-1:0] LAST_CELL = CELL_AW'(CELLS - 1);
  localparam logic [CELL_AW-1:0] ROW_STEP  = CELL_AW'(GRID_SIDE);
  localparam logic [EXT_W-1:0]   SIDE_EXT  = EXT_W'(GRID_SIDE);
  localparam logic [LEN_W-1:0]   LEN_ONE   = LEN_W'(1);

  typedef enum logic [1:0] {G_IDLE, G_SETUP, G_WALK, G_SWEEP} gstate_t;

  gstate_t                        state;
  logic [rocac_pkg::COORD_W-1:0]  top_q;
  logic [rocac_pkg::COORD_W-1:0]  left_q;
  logic [rocac_pkg::SPAN_W-1:0]   rows_q;
  logic [rocac_pkg::SPAN_W-1:0]   cols_q;
  logic [rocac_pkg::ID_W-1:0]     id_q;
  logic [CELL_AW-1:0]             cur_addr;
  logic [CELL_AW-1:0]             row_base;
  logic [CELL_AW-1:0]             sweep_addr;
  logic [CELL_AW-1:0]             wr_addr;
  logic [LEN_W-1:0]               row_left;
  logic [LEN_W-1:0]               col_left;
  logic [LEN_W-1:0]               col_len;
  logic                           rd_valid;

  logic [rocac_pkg::ID_W-1:0]     owner_mem [CELLS];
  logic [rocac_pkg::ID_W-1:0]     owner_rdata;

  logic [EXT_W-1:0]               row_end;
  logic [EXT_W-1:0]               col_end;
  logic [EXT_W-1:0]               row_cnt;
  logic [EXT_W-1:0]               col_cnt;
  logic [CELL_AW-1:0]             base_addr;
  logic [CELL_AW-1:0]             row_base_next;
  logic                           mem_we;
  logic [CELL_AW-1:0]             mem_waddr;
  logic [rocac_pkg::ID_W-1:0]     mem_wdata;

  always_comb begin
    row_end = EXT_W'(top_q) + EXT_W'(rows_q);
    if (row_end > SIDE_EXT) begin
      row_end = SIDE_EXT;
    end
    col_end = EXT_W'(left_q) + EXT_W'(cols_q);
    if (col_end > SIDE_EXT) begin
      col_end = SIDE_EXT;
    end
    row_cnt = (row_end > EXT_W'(top_q)) ? row_end - EXT_W'(top_q) : '0;
    col_cnt = (col_end > EXT_W'(left_q)) ? col_end - EXT_W'(left_q) : '0;
    base_addr = CELL_AW'(top_q) * ROW_STEP + CELL_AW'(left_q);
    row_base_next = row_base + ROW_STEP;
  end

  assign mem_we    = (state == G_SWEEP) || rd_valid;
  assign mem_waddr = (state == G_SWEEP) ? sweep_addr : wr_addr;
  assign mem_wdata = (state == G_SWEEP) ? '0 : id_q;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      owner_mem[mem_waddr] <= mem_wdata;
    end
    owner_rdata <= owner_mem[cur_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= G_SWEEP;
      sweep_addr <= '0;
      rd_valid   <= 1'b0;
    end else begin
      rd_valid <= (state == G_WALK);
      wr_addr  <= cur_addr;
      unique case (state)
        G_IDLE: begin
          if (cmd.clear) begin
            sweep_addr <= '0;
            state      <= G_SWEEP;
          end else if (cmd.paint) begin
            top_q  <= cmd.top_row;
            left_q <= cmd.left_col;
            rows_q <= cmd.span_rows;
            cols_q <= cmd.span_cols;
            id_q   <= cmd.id;
            state  <= G_SETUP;
          end
        end
        G_SETUP: begin
          row_left <= LEN_W'(row_cnt);
          col_left <= LEN_W'(col_cnt);
          col_len  <= LEN_W'(col_cnt);
          cur_addr <= base_addr;
          row_base <= base_addr;
          state    <= (row_cnt == '0 || col_cnt == '0) ? G_IDLE : G_WALK;
        end
        G_WALK: begin
          if (col_left == LEN_ONE) begin
            if (row_left == LEN_ONE) begin
              state <= G_IDLE;
            end else begin
              row_left <= row_left - LEN_ONE;
              row_base <= row_base_next;
              cur_addr <= row_base_next;
              col_left <= col_len;
            end
          end else begin
            cur_addr <= cur_addr + CELL_AW'(1);
            col_left <= col_left - LEN_ONE;
          end
        end
        G_SWEEP: begin
          sweep_addr <= sweep_addr + CELL_AW'(1);
          if (sweep_addr == LAST_CELL) begin
            state <= G_IDLE;
          end
        end
        default: begin
          state <= G_IDLE;
        end
      endcase
    end
  end

  assign stat.active     = (state != G_IDLE) || rd_valid;
  assign stat.beat_valid = rd_valid;
  assign stat.old_owner  = owner_rdata;

endmodule

// File: rtl/core/rocac_area.sv
// ----------------------------------------------------------------------------
// Sheet area store
// Holds the visible-area counter of every sheet, decrements the counter of
// each overwritten owner with one-deep forwarding, and serves report reads.
// ----------------------------------------------------------------------------
module rocac_area #(
  parameter int GRID_SIDE  = 256,
  parameter int MAX_SHEETS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  rocac_pkg::area_cmd_t  cmd,
  input  rocac_pkg::grid_stat_t beat,
  output rocac_pkg::area_stat_t stat
);

  localparam int AREA_W = $clog2(GRID_SIDE * GRID_SIDE + 1);
  localparam int AIDX_W = $clog2(MAX_SHEETS + 1);
  localparam logic [AIDX_W-1:0] LAST_IDX = AIDX_W'(MAX_SHEETS);

  logic [AREA_W-1:0] area_mem [MAX_SHEETS + 1];
  logic [AREA_W-1:0] area_rdata;

  logic              sweeping;
  logic [AIDX_W-1:0] sweep_idx;
  logic              c_valid;
  logic [AIDX_W-1:0] c_owner;
  logic              w_valid;
  logic [AIDX_W-1:0] w_owner;
  logic [AREA_W-1:0] w_data;
  logic [AREA_W-1:0] count;

  logic [AIDX_W-1:0] raddr;
  logic [AREA_W-1:0] cur_val;
  logic              dec_we;
  logic              mem_we;
  logic [AIDX_W-1:0] mem_waddr;
  logic [AREA_W-1:0] mem_wdata;

  assign raddr   = cmd.report_rd ? cmd.id[AIDX_W-1:0] : beat.old_owner[AIDX_W-1:0];
  assign cur_val = (w_valid && w_owner == c_owner) ? w_data : area_rdata;
  assign dec_we  = c_valid && (cur_val != '0);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = c_owner;
    mem_wdata = cur_val - AREA_W'(1);
    if (sweeping) begin
      mem_we    = 1'b1;
      mem_waddr = sweep_idx;
      mem_wdata = '0;
    end else if (cmd.commit) begin
      mem_we    = 1'b1;
      mem_waddr = cmd.id[AIDX_W-1:0];
      mem_wdata = count;
    end else if (dec_we) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      area_mem[mem_waddr] <= mem_wdata;
    end
    area_rdata <= area_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweeping  <= 1'b1;
      sweep_idx <= '0;
      c_valid   <= 1'b0;
      w_valid   <= 1'b0;
    end else begin
      if (cmd.clear) begin
        sweeping  <= 1'b1;
        sweep_idx <= '0;
      end else if (sweeping) begin
        sweep_idx <= sweep_idx + AIDX_W'(1);
        if (sweep_idx == LAST_IDX) begin
          sweeping <= 1'b0;
        end
      end
      c_valid <= beat.beat_valid && (beat.old_owner != '0);
      c_owner <= beat.old_owner[AIDX_W-1:0];
      w_valid <= dec_we;
      w_owner <= c_owner;
      w_data  <= cur_val - AREA_W'(1);
      if (cmd.paint_start) begin
        count <= '0;
      end else if (beat.beat_valid) begin
        count <= count + AREA_W'(1);
      end
    end
  end

  assign stat.busy     = sweeping || c_valid;
  assign stat.rd_area  = rocac_pkg::AREA_OUT_W'(area_rdata);
  assign stat.new_area = rocac_pkg::AREA_OUT_W'(count);

endmodule

// File: rtl/core/rectangle_overlay_area_counter_core.sv
// ----------------------------------------------------------------------------
// Rectangle overlay area counter
// Paints rectangles onto a grid of owner ids and keeps the visible area of
// every sheet.
// ----------------------------------------------------------------------------
// A command transfers when start is high and busy is low. Results appear on
// status, sheet_id, visible_area and last for one cycle each, marked by
// strobe; the receiver cannot stall them, and last marks the final result.
// A paint walks the clipped rectangle at one cell per cycle through the cell
// store, and busy stays high until the walk and the counter updates are done;
// its one result follows that.
// A paint beyond the sheet limit and a report with no sheets answer in the
// cycle right after the transfer with busy low; command three answers nothing.
// A report of n sheets issues one area store read per cycle and delivers n
// results, one per cycle, each through the area read register and pend_valid.
// A clear sweeps the cell store one entry per cycle, then reports once. After
// reset the same sweep runs with busy high before the first command is taken.
// The old owner's counter is updated by read, modify and write with
// forwarding, so the walk never pauses.
// ----------------------------------------------------------------------------
module rectangle_overlay_area_counter_core #(
  parameter int GRID_SIDE  = 256,
  parameter int MAX_SHEETS = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [rocac_pkg::CMD_W-1:0]        command,
  input  logic [rocac_pkg::COORD_W-1:0]      top_row,
  input  logic [rocac_pkg::COORD_W-1:0]      left_col,
  input  logic [rocac_pkg::SPAN_W-1:0]       span_rows,
  input  logic [rocac_pkg::SPAN_W-1:0]       span_cols,
  output logic                               strobe,
  output logic [rocac_pkg::STAT_W-1:0]       status,
  output logic [rocac_pkg::ID_W-1:0]         sheet_id,
  output logic [rocac_pkg::AREA_OUT_W-1:0]   visible_area,
  output logic                               last
);

  localparam logic [rocac_pkg::ID_W-1:0] SHEET_LIMIT = rocac_pkg::ID_W'(MAX_SHEETS);
  localparam logic [rocac_pkg::ID_W-1:0] ID_ONE      = rocac_pkg::ID_W'(1);

  typedef enum logic [2:0] {S_INIT, S_IDLE, S_PAINT, S_REPORT, S_CLEAR} state_t;

  state_t                      state;
  logic [rocac_pkg::ID_W-1:0]  sheets;
  logic [rocac_pkg::ID_W-1:0]  cur_id;
  logic [rocac_pkg::ID_W-1:0]  rep_id;
  logic                        pend_valid;
  logic [rocac_pkg::ID_W-1:0]  pend_id;
  logic                        pend_last;

  rocac_pkg::grid_cmd_t  grid_cmd;
  rocac_pkg::grid_stat_t grid_stat;
  rocac_pkg::area_cmd_t  area_cmd;
  rocac_pkg::area_stat_t area_stat;

  logic accept;
  logic paint_ok;
  logic clear_go;
  logic units_idle;

  assign busy       = (state != S_IDLE) || pend_valid;
  assign accept     = start && !busy;
  assign paint_ok   = accept && (command == rocac_pkg::CMD_PAINT) && (sheets != SHEET_LIMIT);
  assign clear_go   = accept && (command == rocac_pkg::CMD_CLEAR);
  assign units_idle = !grid_stat.active && !area_stat.busy;

  always_comb begin
    grid_cmd.paint     = paint_ok;
    grid_cmd.clear     = clear_go;
    grid_cmd.top_row   = top_row;
    grid_cmd.left_col  = left_col;
    grid_cmd.span_rows = span_rows;
    grid_cmd.span_cols = span_cols;
    grid_cmd.id        = sheets + ID_ONE;

    area_cmd.clear       = clear_go;
    area_cmd.paint_start = paint_ok;
    area_cmd.commit      = (state == S_PAINT) && units_idle;
    area_cmd.report_rd   = (state == S_REPORT);
    area_cmd.id          = (state == S_REPORT) ? rep_id : cur_id;
  end

  rocac_grid #(
    .GRID_SIDE (GRID_SIDE)
  ) u_grid (
    .clk  (clk),
    .rst  (rst),
    .cmd  (grid_cmd),
    .stat (grid_stat)
  );

  rocac_area #(
    .GRID_SIDE  (GRID_SIDE),
    .MAX_SHEETS (MAX_SHEETS)
  ) u_area (
    .clk  (clk),
    .rst  (rst),
    .cmd  (area_cmd),
    .beat (grid_stat),
    .stat (area_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      sheets     <= '0;
      pend_valid <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      strobe     <= 1'b0;
      pend_valid <= 1'b0;
      if (pend_valid) begin
        strobe       <= 1'b1;
        status       <= rocac_pkg::STAT_OK;
        sheet_id     <= pend_id;
        visible_area <= area_stat.rd_area;
        last         <= pend_last;
      end
      unique case (state)
        S_INIT: begin
          if (units_idle) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            unique case (command)
              rocac_pkg::CMD_PAINT: begin
                if (sheets == SHEET_LIMIT) begin
                  strobe       <= 1'b1;
                  status       <= rocac_pkg::STAT_LIMIT;
                  sheet_id     <= '0;
                  visible_area <= '0;
                  last         <= 1'b1;
                end else begin
                  sheets <= sheets + ID_ONE;
                  cur_id <= sheets + ID_ONE;
                  state  <= S_PAINT;
                end
              end
              rocac_pkg::CMD_REPORT: begin
                if (sheets == '0) begin
                  strobe       <= 1'b1;
                  status       <= rocac_pkg::STAT_EMPTY;
                  sheet_id     <= '0;
                  visible_area <= '0;
                  last         <= 1'b1;
                end else begin
                  rep_id <= ID_ONE;
                  state  <= S_REPORT;
                end
              end
              rocac_pkg::CMD_CLEAR: begin
                sheets <= '0;
                state  <= S_CLEAR;
              end
              default: begin
              end
            endcase
          end
        end
        S_PAINT: begin
          if (units_idle) begin
            strobe       <= 1'b1;
            status       <= rocac_pkg::STAT_OK;
            sheet_id     <= cur_id;
            visible_area <= area_stat.new_area;
            last         <= 1'b1;
            state        <= S_IDLE;
          end
        end
        S_REPORT: begin
          pend_valid <= 1'b1;
          pend_id    <= rep_id;
          pend_last  <= (rep_id == sheets);
          if (rep_id == sheets) begin
            state <= S_IDLE;
          end else begin
            rep_id <= rep_id + ID_ONE;
          end
        end
        S_CLEAR: begin
          if (units_idle) begin
            strobe       <= 1'b1;
            status       <= rocac_pkg::STAT_CLEARED;
            sheet_id     <= '0;
            visible_area <= '0;
            last         <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    strobe && (status != rocac_pkg::STAT_OK) |-> last)
    else $error("non-ok result without last");

  a_sheet_bound: assert property (@(posedge clk) disable iff (rst)
    sheets <= SHEET_LIMIT)
    else $error("sheet count beyond limit");

  a_idle_units: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !grid_stat.active && !area_stat.busy)
    else $error("units active while idle");

  a_paint_count: assert property (@(posedge clk) disable iff (rst)
    paint_ok |=> busy && (sheets == $past(sheets) + ID_ONE))
    else $error("paint transfer did not take an id");

  a_report_pend: assert property (@(posedge clk) disable iff (rst)
    state == S_REPORT |=> pend_valid)
    else $error("report read without result");

endmodule
